### rtl/ccomp_pkg.sv
// Shared constants, register indexes and the CORDIC angle table
// for the calibrated compass heading core. No dependencies.
`default_nettype none

package ccomp_pkg;

  localparam int SAMPLE_BITS_DEF  = 20;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int OFFSET_BITS  = 20;
  localparam int COEF_BITS    = 16;
  localparam int DECL_BITS    = 16;
  localparam int HEAD_BITS    = 16;
  localparam int CFG_BITS     = 60;
  localparam int CFG_IDX_BITS = 3;

  localparam int DEG_FRAC   = 16;
  localparam int HEAD_FRAC  = 7;
  localparam int ANG_BITS   = 28;
  localparam int ATAN_LEN   = 24;
  localparam int ROUND_SHIFT = DEG_FRAC - HEAD_FRAC;

  localparam logic [CFG_IDX_BITS-1:0] REG_OFFSETS     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SOFT_X      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SOFT_Y      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SOFT_Z      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DECLINATION = 3'd4;

  localparam logic [47:0] SOFT_X_RESET = 48'd16384;
  localparam logic [47:0] SOFT_Y_RESET = 48'd16384 << 16;

  localparam logic signed [ANG_BITS-1:0] QUARTER_TURN = ANG_BITS'(90 << DEG_FRAC);
  localparam logic signed [ANG_BITS-1:0] FULL_CIRCLE  = ANG_BITS'(360 << DEG_FRAC);
  localparam logic signed [ANG_BITS-1:0] TWO_CIRCLES  = ANG_BITS'(720 << DEG_FRAC);
  localparam logic signed [ANG_BITS-1:0] ROUND_HALF   = ANG_BITS'(1 << (ROUND_SHIFT - 1));
  localparam logic [HEAD_BITS-1:0]       HEAD_FULL    = HEAD_BITS'(360 << HEAD_FRAC);

  function automatic logic signed [ANG_BITS-1:0] atan_step(input int idx);
    logic signed [ANG_BITS-1:0] val;
    case (idx)
      0:       val = ANG_BITS'(2949120);
      1:       val = ANG_BITS'(1740967);
      2:       val = ANG_BITS'(919879);
      3:       val = ANG_BITS'(466945);
      4:       val = ANG_BITS'(234379);
      5:       val = ANG_BITS'(117304);
      6:       val = ANG_BITS'(58666);
      7:       val = ANG_BITS'(29335);
      8:       val = ANG_BITS'(14668);
      9:       val = ANG_BITS'(7334);
      10:      val = ANG_BITS'(3667);
      11:      val = ANG_BITS'(1833);
      12:      val = ANG_BITS'(917);
      13:      val = ANG_BITS'(458);
      14:      val = ANG_BITS'(229);
      15:      val = ANG_BITS'(115);
      16:      val = ANG_BITS'(57);
      17:      val = ANG_BITS'(29);
      18:      val = ANG_BITS'(14);
      19:      val = ANG_BITS'(7);
      20:      val = ANG_BITS'(4);
      21:      val = ANG_BITS'(2);
      22:      val = ANG_BITS'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

### rtl/calibrated_compass_heading_core.sv
// Calibrated compass heading: offset removal, soft-iron matrix, CORDIC atan2,
// declination and wrap, as one pipeline. Depends on ccomp_pkg.
//
// channel   direction  handshake            payload
// command   in         start / busy         field_x, field_y, field_z
// result    out        done (strobe)        heading
// config    in         cfg_write            cfg_index, cfg_data
//
// One transaction per cycle while busy is low. Stages in order: offset, multiply,
// sum, quadrant, one CORDIC iteration per stage, declination, wrap and rounding.
// rst is synchronous; busy is high during reset and low otherwise.
// The result strobe cannot be held off, so the pipeline never stalls.
`default_nettype none

module calibrated_compass_heading_core import ccomp_pkg::*; #(
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [SAMPLE_BITS-1:0] field_x,
  input  wire logic signed [SAMPLE_BITS-1:0] field_y,
  input  wire logic signed [SAMPLE_BITS-1:0] field_z,
  output logic                               done,
  output logic [HEAD_BITS-1:0]               heading,
  input  wire logic                          cfg_write,
  input  wire logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  wire logic [CFG_BITS-1:0]           cfg_data
);

  localparam int D_W = ((SAMPLE_BITS > OFFSET_BITS) ? SAMPLE_BITS : OFFSET_BITS) + 1;
  localparam int P_W = D_W + COEF_BITS;
  localparam int S_W = P_W + 2;
  localparam int C_W = S_W + 3;
  localparam int Q_W = ANG_BITS - ROUND_SHIFT;

  logic [CFG_BITS-1:0]         axis_offsets;
  logic [47:0]                 soft_x;
  logic [47:0]                 soft_y;
  logic signed [DECL_BITS-1:0] declination;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_offsets <= '0;
      soft_x       <= SOFT_X_RESET;
      soft_y       <= SOFT_Y_RESET;
      declination  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_OFFSETS:     axis_offsets <= cfg_data;
        REG_SOFT_X:      soft_x       <= cfg_data[47:0];
        REG_SOFT_Y:      soft_y       <= cfg_data[47:0];
        REG_SOFT_Z:      ;
        REG_DECLINATION: declination  <= $signed(cfg_data[DECL_BITS-1:0]);
        default:         ;
      endcase
    end
  end

  assign busy = rst;

  logic accept;
  assign accept = start && !busy;

  logic signed [D_W-1:0] d_x, d_y, d_z;
  logic                  d_vld;

  always_ff @(posedge clk) begin
    if (rst) d_vld <= 1'b0;
    else     d_vld <= accept;
  end

  always_ff @(posedge clk) begin
    d_x <= D_W'(field_x) - D_W'($signed(axis_offsets[19:0]));
    d_y <= D_W'(field_y) - D_W'($signed(axis_offsets[39:20]));
    d_z <= D_W'(field_z) - D_W'($signed(axis_offsets[59:40]));
  end

  logic signed [P_W-1:0] p_x0, p_x1, p_x2, p_y0, p_y1, p_y2;
  logic                  p_vld;

  always_ff @(posedge clk) begin
    if (rst) p_vld <= 1'b0;
    else     p_vld <= d_vld;
  end

  always_ff @(posedge clk) begin
    p_x0 <= P_W'($signed(soft_x[15:0]))  * P_W'(d_x);
    p_x1 <= P_W'($signed(soft_x[31:16])) * P_W'(d_y);
    p_x2 <= P_W'($signed(soft_x[47:32])) * P_W'(d_z);
    p_y0 <= P_W'($signed(soft_y[15:0]))  * P_W'(d_x);
    p_y1 <= P_W'($signed(soft_y[31:16])) * P_W'(d_y);
    p_y2 <= P_W'($signed(soft_y[47:32])) * P_W'(d_z);
  end

  logic signed [S_W-1:0] s_x, s_y;
  logic                  s_vld;

  always_ff @(posedge clk) begin
    if (rst) s_vld <= 1'b0;
    else     s_vld <= p_vld;
  end

  always_ff @(posedge clk) begin
    s_x <= S_W'(p_x0) + S_W'(p_x1) + S_W'(p_x2);
    s_y <= S_W'(p_y0) + S_W'(p_y1) + S_W'(p_y2);
  end

  logic signed [C_W-1:0]      c_re   [CORDIC_STEPS+1];
  logic signed [C_W-1:0]      c_im   [CORDIC_STEPS+1];
  logic signed [ANG_BITS-1:0] c_z    [CORDIC_STEPS+1];
  logic                       c_zero [CORDIC_STEPS+1];
  logic                       c_vld  [CORDIC_STEPS+1];

  logic signed [C_W-1:0] re_in, im_in;
  assign re_in = C_W'(s_y);
  assign im_in = C_W'(s_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= CORDIC_STEPS; k++) c_vld[k] <= 1'b0;
    end else begin
      c_vld[0] <= s_vld;
      for (int k = 0; k < CORDIC_STEPS; k++) c_vld[k+1] <= c_vld[k];
    end
  end

  always_ff @(posedge clk) begin
    c_zero[0] <= (s_x == '0) && (s_y == '0);
    if (re_in[C_W-1] && !im_in[C_W-1]) begin
      c_re[0] <= im_in;
      c_im[0] <= -re_in;
      c_z[0]  <= QUARTER_TURN;
    end else if (re_in[C_W-1]) begin
      c_re[0] <= -im_in;
      c_im[0] <= re_in;
      c_z[0]  <= -QUARTER_TURN;
    end else begin
      c_re[0] <= re_in;
      c_im[0] <= im_in;
      c_z[0]  <= '0;
    end
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      c_zero[k+1] <= c_zero[k];
      if (!c_im[k][C_W-1]) begin
        c_re[k+1] <= c_re[k] + (c_im[k] >>> k);
        c_im[k+1] <= c_im[k] - (c_re[k] >>> k);
        c_z[k+1]  <= c_z[k] + atan_step(k);
      end else begin
        c_re[k+1] <= c_re[k] - (c_im[k] >>> k);
        c_im[k+1] <= c_im[k] + (c_re[k] >>> k);
        c_z[k+1]  <= c_z[k] - atan_step(k);
      end
    end
  end

  logic signed [ANG_BITS-1:0] a_sum;
  logic                       a_vld;

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else     a_vld <= c_vld[CORDIC_STEPS];
  end

  always_ff @(posedge clk) begin
    a_sum <= (c_zero[CORDIC_STEPS] ? '0 : c_z[CORDIC_STEPS])
             + (ANG_BITS'(declination) <<< ROUND_SHIFT);
  end

  logic signed [ANG_BITS-1:0] w_ang, w_ang_next;
  logic                       w_vld;

  always_comb begin
    if (a_sum < -FULL_CIRCLE)    w_ang_next = a_sum + TWO_CIRCLES;
    else if (a_sum[ANG_BITS-1])  w_ang_next = a_sum + FULL_CIRCLE;
    else if (a_sum >= FULL_CIRCLE) w_ang_next = a_sum - FULL_CIRCLE;
    else                         w_ang_next = a_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) w_vld <= 1'b0;
    else     w_vld <= a_vld;
  end

  always_ff @(posedge clk) begin
    w_ang <= w_ang_next;
  end

  logic [ANG_BITS-1:0] r_ang;
  logic [Q_W-1:0]      q_ang;
  logic [HEAD_BITS-1:0] heading_next;

  always_comb begin
    r_ang        = w_ang + ROUND_HALF;
    q_ang        = r_ang[ANG_BITS-1:ROUND_SHIFT];
    heading_next = (q_ang == Q_W'(HEAD_FULL)) ? '0 : q_ang[HEAD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= w_vld;
  end

  always_ff @(posedge clk) begin
    heading <= heading_next;
  end

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    done |-> heading < HEAD_FULL)
    else $error("heading out of range");

  a_quadrant: assert property (@(posedge clk) disable iff (rst)
    c_vld[0] |-> !c_re[0][C_W-1])
    else $error("pre-rotated vector not in right half-plane");

  a_wrap: assert property (@(posedge clk) disable iff (rst)
    w_vld |-> (!w_ang[ANG_BITS-1] && w_ang < FULL_CIRCLE))
    else $error("wrapped angle out of range");

  a_reset: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe after reset");

  a_decl: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && cfg_index == REG_DECLINATION) |=>
      declination == $signed($past(cfg_data[DECL_BITS-1:0])))
    else $error("declination write lost");

endmodule

`default_nettype wire

### tb/calibrated_compass_heading_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for calibrated_compass_heading_core: directed and random
// magnetometer samples, each heading checked against an in-bench predictor.
// Depends on ccomp_pkg and the core RTL.

module calibrated_compass_heading_core_tb;
  import ccomp_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int PIPE_DEPTH = CORDIC_STEPS_DEF + 7;
  localparam longint CIRCLE_Q16 = longint'(360) <<< DEG_FRAC;
  localparam longint QUARTER_Q16 = longint'(90) <<< DEG_FRAC;
  localparam int ATAN_ENTRIES = 24;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [SB-1:0] field_x = '0;
  logic signed [SB-1:0] field_y = '0;
  logic signed [SB-1:0] field_z = '0;
  logic done;
  logic [HEAD_BITS-1:0] heading;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_OFFSETS;
  logic [CFG_BITS-1:0] cfg_data = '0;

  longint atan_deg_q16 [ATAN_ENTRIES] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  logic [CFG_BITS-1:0] iron_offsets = '0;
  logic [47:0] soft_rows [3] = '{48'd16384, 48'd16384 << 16, 48'd16384 << 32};
  logic signed [DECL_BITS-1:0] decl_q7 = '0;
  logic idle_enabled = 1'b1;

  logic [HEAD_BITS-1:0] pending_headings [$];
  logic [HEAD_BITS-1:0] heading_due;
  int mismatch_count = 0;

  calibrated_compass_heading_core uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .field_x(field_x),
    .field_y(field_y),
    .field_z(field_z),
    .done(done),
    .heading(heading),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [HEAD_BITS-1:0] predict_heading(
    input logic signed [SB-1:0] sx,
    input logic signed [SB-1:0] sy,
    input logic signed [SB-1:0] sz
  );
    logic signed [SB-1:0] axis [3];
    logic signed [OFFSET_BITS-1:0] off;
    logic signed [COEF_BITS-1:0] cf;
    longint d [3];
    longint cx, cy, re, im, ang, t, dre, dim, total, wrapped, q;
    int k, i;
    axis[0] = sx;
    axis[1] = sy;
    axis[2] = sz;
    for (k = 0; k < 3; k++) begin
      off = iron_offsets[OFFSET_BITS*k +: OFFSET_BITS];
      d[k] = longint'(axis[k]) - longint'(off);
    end
    cx = 0;
    cy = 0;
    for (k = 0; k < 3; k++) begin
      cf = soft_rows[0][COEF_BITS*k +: COEF_BITS];
      cx += longint'(cf) * d[k];
      cf = soft_rows[1][COEF_BITS*k +: COEF_BITS];
      cy += longint'(cf) * d[k];
    end
    // atan2(x, y): y is the real part, x the imaginary part
    ang = 0;
    re = cy;
    im = cx;
    if (re != 0 || im != 0) begin
      if (re < 0) begin
        t = re;
        if (im >= 0) begin
          re = im;
          im = -t;
          ang = QUARTER_Q16;
        end else begin
          re = -im;
          im = t;
          ang = -QUARTER_Q16;
        end
      end
      for (i = 0; i < CORDIC_STEPS_DEF; i++) begin
        dre = im >>> i;
        dim = re >>> i;
        if (im >= 0) begin
          re += dre;
          im -= dim;
          ang += (i < ATAN_ENTRIES) ? atan_deg_q16[i] : 0;
        end else begin
          re -= dre;
          im += dim;
          ang -= (i < ATAN_ENTRIES) ? atan_deg_q16[i] : 0;
        end
      end
    end
    total = ang + (longint'(decl_q7) <<< ROUND_SHIFT);
    wrapped = total % CIRCLE_Q16;
    if (wrapped < 0) wrapped += CIRCLE_Q16;
    q = (wrapped + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    if (q >= longint'(HEAD_FULL)) q -= longint'(HEAD_FULL);
    return HEAD_BITS'(q);
  endfunction

  function automatic logic [CFG_BITS-1:0] pack_offsets(input int ox, input int oy, input int oz);
    return {OFFSET_BITS'(oz), OFFSET_BITS'(oy), OFFSET_BITS'(ox)};
  endfunction

  function automatic logic [CFG_BITS-1:0] pack_row(
    input logic [15:0] c0, input logic [15:0] c1, input logic [15:0] c2
  );
    return {12'd0, c2, c1, c0};
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_headings.size() == 0) begin
        $display("%0t: heading with no transaction pending: expected none, actual %0d",
                 $time, heading);
        mismatch_count++;
      end else begin
        heading_due = pending_headings.pop_front();
        if (heading !== heading_due) begin
          $display("%0t: heading mismatch: expected %0d, actual %0d",
                   $time, heading_due, heading);
          mismatch_count++;
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_OFFSETS:     iron_offsets = value;
      REG_SOFT_X:      soft_rows[0] = value[47:0];
      REG_SOFT_Y:      soft_rows[1] = value[47:0];
      REG_SOFT_Z:      soft_rows[2] = value[47:0];
      REG_DECLINATION: decl_q7 = value[DECL_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic write_declination(input int deg_q7);
    logic [DECL_BITS-1:0] dq;
    dq = DECL_BITS'(deg_q7);
    write_reg(REG_DECLINATION, {{(CFG_BITS-DECL_BITS){1'b0}}, dq});
  endtask

  task automatic set_config(
    input logic [CFG_BITS-1:0] offsets,
    input logic [CFG_BITS-1:0] row_x,
    input logic [CFG_BITS-1:0] row_y,
    input logic [CFG_BITS-1:0] row_z,
    input int deg_q7
  );
    write_reg(REG_OFFSETS, offsets);
    write_reg(REG_SOFT_X, row_x);
    write_reg(REG_SOFT_Y, row_y);
    write_reg(REG_SOFT_Z, row_z);
    write_declination(deg_q7);
  endtask

  // hold start until the core takes the sample, then record its heading
  task automatic send_sample(input logic [SB-1:0] x, input logic [SB-1:0] y,
                             input logic [SB-1:0] z);
    start <= 1'b1;
    field_x <= x;
    field_y <= y;
    field_z <= z;
    do @(posedge clk); while (busy);
    pending_headings.push_back(predict_heading(x, y, z));
  endtask

  task automatic drain_headings();
    start <= 1'b0;
    do @(posedge clk); while (pending_headings.size() != 0);
  endtask

  task automatic idle_sender();
    if (idle_enabled && $urandom_range(99) < 47) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_random_sample();
    logic [SB-1:0] v [3];
    logic near_zero;
    int k;
    near_zero = ($urandom_range(3) == 0);
    for (k = 0; k < 3; k++) begin
      if (near_zero)
        v[k] = iron_offsets[OFFSET_BITS*k +: SB] + SB'(int'($urandom_range(32)) - 16);
      else
        v[k] = SB'($urandom);
    end
    idle_sender();
    send_sample(v[0], v[1], v[2]);
  endtask

  task automatic test_default_axes();
    send_sample(SB'(0), SB'(0), SB'(0));
    send_sample(SB'(0), SB'(524287), SB'(0));
    send_sample(SB'(524287), SB'(0), SB'(0));
    send_sample(SB'(0), SB'(-524288), SB'(0));
    send_sample(SB'(-524288), SB'(0), SB'(0));
    send_sample(SB'(524287), SB'(524287), SB'(-524288));
    send_sample(SB'(-524288), SB'(-524288), SB'(524287));
    send_sample(SB'(1), SB'(-1), SB'(0));
    send_sample(SB'(-1), SB'(1), SB'(0));
  endtask

  task automatic test_declination_wrap();
    drain_headings();
    write_declination(23040);
    send_sample(SB'(0), SB'(-1000), SB'(0));
    send_sample(SB'(-5), SB'(3), SB'(0));
    drain_headings();
    write_declination(-23040);
    send_sample(SB'(0), SB'(1000), SB'(0));
    send_sample(SB'(5), SB'(3), SB'(0));
    drain_headings();
    write_declination(0);
  endtask

  task automatic test_offsets();
    drain_headings();
    write_reg(REG_OFFSETS, pack_offsets(-524288, 524287, 1));
    send_sample(SB'(524287), SB'(-524288), SB'(0));
    send_sample(SB'(-524288), SB'(524287), SB'(1));
    send_sample(SB'(0), SB'(0), SB'(0));
  endtask

  task automatic test_soft_iron();
    drain_headings();
    set_config('0, pack_row(16'h7FFF, 16'h8000, 16'h7FFF),
               pack_row(16'h8000, 16'h7FFF, 16'h8000),
               pack_row(16'hFFFF, 16'h0001, 16'h8000), 0);
    send_sample(SB'(524287), SB'(-524288), SB'(524287));
    send_sample(SB'(-524288), SB'(524287), SB'(-524288));
    send_sample(SB'(12345), SB'(-6789), SB'(1));
    drain_headings();
    write_reg(REG_SOFT_X, '0);
    send_sample(SB'(1000), SB'(-3000), SB'(0));
  endtask

  task automatic test_random_phases();
    int phase, n, deg_q7;
    logic [CFG_BITS-1:0] rows [3];
    for (phase = 0; phase < 8; phase++) begin
      drain_headings();
      case (phase % 4)
        0: deg_q7 = 23040;
        1: deg_q7 = -23040;
        default: deg_q7 = int'($urandom_range(46080)) - 23040;
      endcase
      if (phase == 2) begin
        rows[0] = pack_row(16'h4000, 16'h0000, 16'h0000);
        rows[1] = pack_row(16'h0000, 16'h4000, 16'h0000);
        rows[2] = pack_row(16'h0000, 16'h0000, 16'h4000);
      end else begin
        for (n = 0; n < 3; n++) rows[n] = {12'd0, 48'({$urandom, $urandom})};
      end
      set_config(CFG_BITS'({$urandom, $urandom}), rows[0], rows[1], rows[2], deg_q7);
      idle_enabled = (phase != 3);
      for (n = 0; n < 250; n++) begin
        if (phase == 5 && n == 125) drain_headings();
        send_random_sample();
      end
    end
    idle_enabled = 1'b1;
  endtask

  initial begin
    int wait_cycles;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (busy);
    test_default_axes();
    test_declination_wrap();
    test_offsets();
    test_soft_iron();
    test_random_phases();
    start <= 1'b0;
    wait_cycles = 0;
    while (pending_headings.size() != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (pending_headings.size() != 0)
      $display("%0t: %0d headings never arrived", $time, pending_headings.size());
    if (mismatch_count == 0 && pending_headings.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### calibrated_compass_heading_core.f
rtl/ccomp_pkg.sv
rtl/calibrated_compass_heading_core.sv
tb/calibrated_compass_heading_core_tb.sv
